// ===== rtl/core/urbeol_pkg.sv =====
// ----------------------------------------------------------------------------
// urbeol_pkg
// Shared constants and types for the serial ring buffer with end-of-line
// translation: command codes, end-of-line codes, sequencer states, result.
// ----------------------------------------------------------------------------
`default_nettype none

package urbeol_pkg;

    // Default ring index width (ring holds 2**RING_INDEX_BITS entries)
    localparam int RING_INDEX_BITS = 8;

    localparam int CMD_BITS  = 3;
    localparam int BYTE_BITS = 8;

    // Command codes carried on s_tuser
    localparam logic [CMD_BITS-1:0] CMD_RX_BYTE   = 3'd0;
    localparam logic [CMD_BITS-1:0] CMD_APP_READ  = 3'd1;
    localparam logic [CMD_BITS-1:0] CMD_APP_WRITE = 3'd2;
    localparam logic [CMD_BITS-1:0] CMD_START_OUT = 3'd3;
    localparam logic [CMD_BITS-1:0] CMD_TX_DONE   = 3'd4;
    localparam logic [CMD_BITS-1:0] CMD_DISCARD   = 3'd5;

    // Line control characters
    localparam logic [BYTE_BITS-1:0] CH_CR = 8'h0D;
    localparam logic [BYTE_BITS-1:0] CH_LF = 8'h0A;

    // Last end-of-line character seen by the reader
    typedef enum logic [1:0] {
        EOL_NONE = 2'd0,
        EOL_CR   = 2'd1,
        EOL_LF   = 2'd2
    } eol_t;

    // Item sequencer
    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_EXEC  = 2'd1,
        ST_SPLIT = 2'd2
    } state_t;

    // Result fields, lowest bit last
    typedef struct packed {
        logic                 tx_empty;
        logic                 rx_empty;
        logic                 tx_ready_event;
        logic                 rx_ready_event;
        logic                 write_accepted;
        logic [BYTE_BITS-1:0] line_byte;
        logic                 line_valid;
        logic [BYTE_BITS-1:0] app_byte;
        logic                 app_valid;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/core/urbeol_ram.sv =====
// ----------------------------------------------------------------------------
// urbeol_ram
// Byte ring storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module urbeol_ram #(
    parameter int ADDR_BITS = urbeol_pkg::RING_INDEX_BITS
) (
    input  wire logic                 clk,
    input  wire logic                 we,
    input  wire logic [ADDR_BITS-1:0] waddr,
    input  wire logic [7:0]           wdata,
    input  wire logic                 re,
    input  wire logic [ADDR_BITS-1:0] raddr,
    output logic      [7:0]           rdata
);

    localparam int DEPTH = 1 << ADDR_BITS;

    logic [7:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/uart_ring_buffer_eol_translation.sv =====
// A transaction is captured at acceptance, when its ring read is issued;
// in execute the read-modify-write is done and the result registered on
// m_tdata. A stalled result holds the next item in execute. A new item is
// taken once the last is done; a cooked-mode LF write adds a split state, as
// CR and LF go through the single transmit memory write port one at a time.
// Reset clears indices, cooked mode, running flag and end-of-line state.
// ----------------------------------------------------------------------------
// uart_ring_buffer_eol_translation
// Receive and transmit byte rings with optional CR/LF translation.
// ----------------------------------------------------------------------------
`default_nettype none

module uart_ring_buffer_eol_translation #(
    parameter int RING_INDEX_BITS = urbeol_pkg::RING_INDEX_BITS
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Configuration write: cooked_mode
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_data,
    // Command stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data
    input  wire logic [2:0]  s_tuser,   // [2:0] cmd
    // Result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata    // [0] app_valid, [8:1] app_byte,
                                        // [9] line_valid, [17:10] line_byte,
                                        // [18] write_accepted,
                                        // [19] rx_ready_event,
                                        // [20] tx_ready_event, [21] rx_empty,
                                        // [22] tx_empty, [23] zero
);

    localparam int N = RING_INDEX_BITS;
    localparam logic [N-1:0] IDX_ONE  = N'(1);
    localparam logic [N-1:0] IDX_TWO  = N'(2);
    localparam logic [N-1:0] IDX_MASK = {N{1'b1}};

    urbeol_pkg::state_t  state_reg, state_next;
    urbeol_pkg::eol_t    eol_reg, eol_next;
    urbeol_pkg::result_t out_reg, out_next;

    logic         cooked_reg;
    logic         m_valid_reg, m_valid_next;
    logic [2:0]   cmd_reg;
    logic [7:0]   data_reg;
    logic [N-1:0] rx_wr_reg, rx_wr_next;
    logic [N-1:0] rx_rd_reg, rx_rd_next;
    logic [N-1:0] tx_wr_reg, tx_wr_next;
    logic [N-1:0] tx_rd_reg, tx_rd_next;
    logic         running_reg, running_next;

    logic         accept;
    logic         out_free;
    logic         rx_we, tx_we;
    logic [7:0]   rx_wdata, tx_wdata;
    logic [7:0]   rx_rdata, tx_rdata;
    logic [N-1:0] tx_used, tx_room;
    logic         expand;
    logic         fits;
    logic         is_eol;
    urbeol_pkg::eol_t code;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == urbeol_pkg::ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {1'b0, out_reg};

    // Ring storage; reads issue at acceptance, using current read indices
    urbeol_ram #(.ADDR_BITS(N)) u_rx_ram (
        .clk   (clk),
        .we    (rx_we),
        .waddr (rx_wr_reg),
        .wdata (rx_wdata),
        .re    (accept),
        .raddr (rx_rd_reg),
        .rdata (rx_rdata)
    );

    urbeol_ram #(.ADDR_BITS(N)) u_tx_ram (
        .clk   (clk),
        .we    (tx_we),
        .waddr (tx_wr_reg),
        .wdata (tx_wdata),
        .re    (accept),
        .raddr (tx_rd_reg),
        .rdata (tx_rdata)
    );

    // Transmit ring occupancy and write admission
    assign tx_used = tx_wr_reg - tx_rd_reg;
    assign tx_room = IDX_MASK - tx_used;
    assign expand  = cooked_reg && (data_reg == urbeol_pkg::CH_LF);
    assign fits    = expand ? (tx_room >= IDX_TWO) : (tx_room != '0);

    // Classify the byte popped from the receive ring
    assign is_eol = (rx_rdata == urbeol_pkg::CH_CR) || (rx_rdata == urbeol_pkg::CH_LF);
    assign code   = (rx_rdata == urbeol_pkg::CH_CR) ? urbeol_pkg::EOL_CR
                                                    : urbeol_pkg::EOL_LF;

    // Sequencer: execute one item per pass, with a second write for cooked LF
    always_comb
    begin
        state_next   = state_reg;
        eol_next     = eol_reg;
        out_next     = out_reg;
        m_valid_next = m_valid_reg && !m_tready;
        rx_wr_next   = rx_wr_reg;
        rx_rd_next   = rx_rd_reg;
        tx_wr_next   = tx_wr_reg;
        tx_rd_next   = tx_rd_reg;
        running_next = running_reg;
        rx_we        = 1'b0;
        tx_we        = 1'b0;
        rx_wdata     = data_reg;
        tx_wdata     = data_reg;

        unique case (state_reg)
            urbeol_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = urbeol_pkg::ST_EXEC;
                end
            end

            urbeol_pkg::ST_EXEC:
            begin
                if (out_free)
                begin
                    out_next     = '0;
                    m_valid_next = 1'b1;
                    state_next   = urbeol_pkg::ST_IDLE;

                    unique case (cmd_reg)
                        urbeol_pkg::CMD_RX_BYTE:
                        begin
                            rx_we = 1'b1;
                            out_next.rx_ready_event = (rx_rd_reg == rx_wr_reg);
                            rx_wr_next = rx_wr_reg + IDX_ONE;
                        end

                        urbeol_pkg::CMD_APP_READ:
                        begin
                            if (rx_rd_reg != rx_wr_reg)
                            begin
                                rx_rd_next = rx_rd_reg + IDX_ONE;
                                if (cooked_reg && is_eol)
                                begin
                                    // Fold CR, LF, CRLF, LFCR into one LF
                                    if (eol_reg == urbeol_pkg::EOL_NONE || eol_reg == code)
                                    begin
                                        eol_next           = code;
                                        out_next.app_valid = 1'b1;
                                        out_next.app_byte  = urbeol_pkg::CH_LF;
                                    end
                                end
                                else
                                begin
                                    eol_next           = urbeol_pkg::EOL_NONE;
                                    out_next.app_valid = 1'b1;
                                    out_next.app_byte  = rx_rdata;
                                end
                            end
                        end

                        urbeol_pkg::CMD_APP_WRITE:
                        begin
                            if (fits)
                            begin
                                tx_we                   = 1'b1;
                                tx_wr_next              = tx_wr_reg + IDX_ONE;
                                out_next.write_accepted = 1'b1;
                                if (expand)
                                begin
                                    tx_wdata   = urbeol_pkg::CH_CR;
                                    state_next = urbeol_pkg::ST_SPLIT;
                                end
                            end
                        end

                        urbeol_pkg::CMD_START_OUT:
                        begin
                            if (!running_reg && (tx_rd_reg != tx_wr_reg))
                            begin
                                running_next        = 1'b1;
                                out_next.line_valid = 1'b1;
                                out_next.line_byte  = tx_rdata;
                                tx_rd_next          = tx_rd_reg + IDX_ONE;
                            end
                        end

                        urbeol_pkg::CMD_TX_DONE:
                        begin
                            if (tx_rd_reg != tx_wr_reg)
                            begin
                                out_next.line_valid = 1'b1;
                                out_next.line_byte  = tx_rdata;
                                tx_rd_next          = tx_rd_reg + IDX_ONE;
                            end
                            else
                            begin
                                running_next            = 1'b0;
                                out_next.tx_ready_event = 1'b1;
                            end
                        end

                        urbeol_pkg::CMD_DISCARD:
                        begin
                            rx_rd_next = rx_wr_reg;
                        end

                        default:
                        begin
                        end
                    endcase

                    out_next.rx_empty = (rx_rd_next == rx_wr_next);
                    out_next.tx_empty = (tx_rd_next == tx_wr_next);
                end
            end

            urbeol_pkg::ST_SPLIT:
            begin
                // Second half of a cooked LF: store the LF after its CR
                tx_we      = 1'b1;
                tx_wr_next = tx_wr_reg + IDX_ONE;
                state_next = urbeol_pkg::ST_IDLE;
            end

            default:
            begin
                state_next = urbeol_pkg::ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= urbeol_pkg::ST_IDLE;
            eol_reg     <= urbeol_pkg::EOL_NONE;
            cooked_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
            rx_wr_reg   <= '0;
            rx_rd_reg   <= '0;
            tx_wr_reg   <= '0;
            tx_rd_reg   <= '0;
            running_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            eol_reg     <= eol_next;
            m_valid_reg <= m_valid_next;
            rx_wr_reg   <= rx_wr_next;
            rx_rd_reg   <= rx_rd_next;
            tx_wr_reg   <= tx_wr_next;
            tx_rd_reg   <= tx_rd_next;
            running_reg <= running_next;
            if (cfg_valid && cfg_ready)
            begin
                cooked_reg <= cfg_data;
            end
        end
    end

    // Payload: captured command and result
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg  <= s_tuser;
            data_reg <= s_tdata;
        end
        out_reg <= out_next;
    end

    // Checks
    a_split_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == urbeol_pkg::ST_SPLIT |-> $past(state_reg) == urbeol_pkg::ST_EXEC)
        else $error("split write without a preceding execute");

    a_one_byte_kind: assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg |-> !(out_reg.app_valid && out_reg.line_valid))
        else $error("result delivers to both application and line");

    a_rx_event_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg && out_reg.rx_ready_event |-> !out_reg.rx_empty)
        else $error("receive ready event with empty receive ring");

    a_tx_event_empty: assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg && out_reg.tx_ready_event |-> out_reg.tx_empty && !running_reg)
        else $error("transmit idle event with bytes left or still running");

    a_split_accepted: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == urbeol_pkg::ST_SPLIT |-> m_valid_reg && out_reg.write_accepted)
        else $error("second transmit write for a refused item");

endmodule

`default_nettype wire
